/* hdl/ibohist_pkg.sv */
// Shared constants, types and codes of the interval bin occupancy histogram.
package ibohist_pkg;

  localparam int DAYS            = 7;
  localparam int LABELS          = 8;
  localparam int MAX_BINS        = 256;
  localparam int CNT_W           = 16;
  localparam int SEC_W           = 17;
  localparam int SECONDS_PER_DAY = 24 * 60 * 60;
  localparam int BW_RESET        = 60 * 60;
  localparam int COUNT_MAX       = (1 << CNT_W) - 1;
  localparam int ROWS            = DAYS * MAX_BINS;
  localparam int ADDR_W          = $clog2(ROWS);
  localparam int BIN_W           = $clog2(MAX_BINS);
  localparam int ROW_W           = LABELS * CNT_W;
  localparam int REG_BIN_SECONDS = 0;

  typedef logic [LABELS-1:0][CNT_W-1:0] row_t;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_REVERSED = 2'd1,
    STAT_CLIPPED  = 2'd2,
    STAT_SATURATE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_MOD,
    ST_RDISSUE,
    ST_RDWAIT,
    ST_DAYCLR,
    ST_DONE
  } state_e;

endpackage

/* hdl/interval_bin_occupancy_histogram_core.sv */
// Interval bin occupancy histogram: per day, bin and label counters of occupied seconds.
// One item at a time. The counters live in one RAM of DAYS*MAX_BINS rows (1792), each row
// holding the counters of all labels of one day and bin. After reset a clearing pass writes
// every row, during which no item is taken (configuration writes still are).
// In an add item a one-bit-per-cycle divider finds the first bin, then each bin it touches
// costs a RAM read and a write. A reversed or out-of-range add, a no-op and an ignored
// clear go straight to the result, a read issues a RAM read, and a day clear writes the
// day's MAX_BINS rows, one row written per cycle. The result register lets the next item
// in while a result waits on the output side.
module interval_bin_occupancy_histogram_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // day[2:0], label[5:3], start_second[22:6],
                                     // stop_second[39:23], bin_index[47:40]
  input  logic [1:0]  s_axis_tuser,  // mode[1:0]
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // count[15:0]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  localparam int SW = ibohist_pkg::SEC_W;
  localparam int AW = ibohist_pkg::ADDR_W;
  localparam int CW = ibohist_pkg::CNT_W;
  localparam int PROD_W = SW + 9;

  ibohist_pkg::state_e state_q, state_d;

  logic [SW-1:0] bin_seconds_q, bin_seconds_d;
  logic [2:0]    day_q, day_d;
  logic [2:0]    label_q, label_d;
  logic [SW-1:0] start_q, start_d;
  logic [SW-1:0] stop_q, stop_d;
  logic [7:0]    bidx_q, bidx_d;
  logic [SW-1:0] dvd_q, dvd_d;
  logic [SW-1:0] rem_q, rem_d;
  logic [SW-1:0] bin_q, bin_d;
  logic [4:0]    div_cnt_q, div_cnt_d;
  logic [SW-1:0] lo_q, lo_d;
  logic [SW-1:0] ov_q, ov_d;
  logic          sat_q, sat_d;
  logic          rd_ok_q, rd_ok_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [CW-1:0] res_count_q, res_count_d;
  ibohist_pkg::status_e res_status_q, res_status_d;
  logic          out_valid_q, out_valid_d;
  logic [CW-1:0] out_count_q, out_count_d;
  logic [1:0]    out_status_q, out_status_d;

  logic             in_fire;
  logic             cfg_we;
  logic [2:0]       in_day;
  logic [2:0]       in_label;
  logic [SW-1:0]    in_start;
  logic [SW-1:0]    in_stop;
  logic [7:0]       in_bidx;
  logic [SW-1:0]    bw;
  logic [SW:0]      trial;
  logic             trial_ge;
  logic [SW-1:0]    rem_nxt;
  logic             div_last;
  logic [SW:0]      hi;
  logic             go;
  logic [SW-1:0]    a_sel;
  logic [SW-1:0]    e_sel;
  logic [SW-1:0]    ov;
  logic             clipped;
  logic [AW-1:0]    day_base;
  logic [AW-1:0]    bin_addr;
  logic [AW-1:0]    rd_addr;
  logic [PROD_W-1:0] rd_prod;
  logic             rd_ok;
  logic [AW-1:0]    clr_last;
  logic             out_free;
  logic [CW+1:0]    sum;
  logic [CW-1:0]    lane;

  ibohist_pkg::row_t rd_row;
  ibohist_pkg::row_t wr_row;

  logic                          ram_en;
  logic                          ram_we;
  logic [AW-1:0]                 ram_addr;
  logic [ibohist_pkg::ROW_W-1:0] ram_wdata;
  logic [ibohist_pkg::ROW_W-1:0] ram_rdata;

  ibohist_ram #(
    .WIDTH (ibohist_pkg::ROW_W),
    .DEPTH (ibohist_pkg::ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // configuration
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready
                & (paddr[2] == 1'(ibohist_pkg::REG_BIN_SECONDS));
  assign prdata = (paddr[2] == 1'(ibohist_pkg::REG_BIN_SECONDS))
                ? 32'(bin_seconds_q) : '0;
  assign bin_seconds_d = cfg_we ? pwdata[SW-1:0] : bin_seconds_q;

  // handshakes and unpacking
  assign s_axis_tready = (state_q == ibohist_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign in_day        = s_axis_tdata[2:0];
  assign in_label      = s_axis_tdata[5:3];
  assign in_start      = s_axis_tdata[22:6];
  assign in_stop       = s_axis_tdata[39:23];
  assign in_bidx       = s_axis_tdata[47:40];

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_count_q;
  assign m_axis_tuser  = out_status_q;
  assign out_free      = ~out_valid_q | m_axis_tready;

  // datapath
  assign bw       = (bin_seconds_q == '0) ? SW'(1) : bin_seconds_q;
  assign trial    = {rem_q, dvd_q[SW-1]};
  assign trial_ge = trial >= {1'b0, bw};
  assign rem_nxt  = trial_ge ? SW'(trial - {1'b0, bw}) : trial[SW-1:0];
  assign div_last = (div_cnt_q == 5'(SW - 1));

  assign hi      = {1'b0, lo_q} + {1'b0, bw};
  assign go      = (lo_q <= stop_q) && (bin_q < SW'(ibohist_pkg::MAX_BINS))
                 && (hi <= (SW + 1)'(ibohist_pkg::SECONDS_PER_DAY));
  assign a_sel   = (start_q > lo_q) ? start_q : lo_q;
  assign e_sel   = ({1'b0, stop_q} < hi) ? stop_q : hi[SW-1:0];
  assign ov      = (e_sel > a_sel) ? (e_sel - a_sel) : '0;
  assign clipped = stop_q > a_sel;

  assign day_base = AW'(day_q) * AW'(ibohist_pkg::MAX_BINS);
  assign bin_addr = day_base + AW'(bin_q[ibohist_pkg::BIN_W-1:0]);
  assign rd_addr  = day_base + AW'(bidx_q);
  assign rd_prod  = PROD_W'({1'b0, bidx_q} + 9'd1) * PROD_W'(bw);
  assign rd_ok    = (32'(day_q) < ibohist_pkg::DAYS) && (32'(label_q) < ibohist_pkg::LABELS)
                 && (32'(bidx_q) < ibohist_pkg::MAX_BINS)
                 && (rd_prod <= PROD_W'(ibohist_pkg::SECONDS_PER_DAY));
  assign clr_last = (state_q == ibohist_pkg::ST_CLR) ? AW'(ibohist_pkg::ROWS - 1)
                  : day_base + AW'(ibohist_pkg::MAX_BINS - 1);

  assign rd_row = ibohist_pkg::row_t'(ram_rdata);
  assign lane   = rd_row[label_q];
  assign sum    = {2'b00, lane} + (CW + 2)'(ov_q);

  always_comb begin
    wr_row          = rd_row;
    wr_row[label_q] = (sum > (CW + 2)'(ibohist_pkg::COUNT_MAX)) ? CW'(ibohist_pkg::COUNT_MAX)
                                                                 : sum[CW-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ibohist_pkg::ST_CLR: begin
        if (clr_cnt_q == clr_last) state_d = ibohist_pkg::ST_IDLE;
      end
      ibohist_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (ibohist_pkg::mode_e'(s_axis_tuser))
            ibohist_pkg::MODE_ADD: begin
              if (in_stop < in_start || 32'(in_day) >= ibohist_pkg::DAYS
                  || 32'(in_label) >= ibohist_pkg::LABELS) begin
                state_d = ibohist_pkg::ST_DONE;
              end else begin
                state_d = ibohist_pkg::ST_DIV;
              end
            end
            ibohist_pkg::MODE_CLEAR: begin
              state_d = (32'(in_day) < ibohist_pkg::DAYS) ? ibohist_pkg::ST_DAYCLR
                                                          : ibohist_pkg::ST_DONE;
            end
            ibohist_pkg::MODE_READ: state_d = ibohist_pkg::ST_RDISSUE;
            default:                state_d = ibohist_pkg::ST_DONE;
          endcase
        end
      end
      ibohist_pkg::ST_DIV: begin
        if (div_last) state_d = ibohist_pkg::ST_CHECK;
      end
      ibohist_pkg::ST_CHECK: begin
        state_d = go ? ibohist_pkg::ST_MOD : ibohist_pkg::ST_DONE;
      end
      ibohist_pkg::ST_MOD:     state_d = ibohist_pkg::ST_CHECK;
      ibohist_pkg::ST_RDISSUE: state_d = ibohist_pkg::ST_RDWAIT;
      ibohist_pkg::ST_RDWAIT:  state_d = ibohist_pkg::ST_DONE;
      ibohist_pkg::ST_DAYCLR: begin
        if (clr_cnt_q == clr_last) state_d = ibohist_pkg::ST_DONE;
      end
      ibohist_pkg::ST_DONE: begin
        if (out_free) state_d = ibohist_pkg::ST_IDLE;
      end
      default: state_d = ibohist_pkg::ST_CLR;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    day_d        = day_q;
    label_d      = label_q;
    start_d      = start_q;
    stop_d       = stop_q;
    bidx_d       = bidx_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    bin_d        = bin_q;
    div_cnt_d    = div_cnt_q;
    lo_d         = lo_q;
    ov_d         = ov_q;
    sat_d        = sat_q;
    rd_ok_d      = rd_ok_q;
    clr_cnt_d    = clr_cnt_q;
    res_count_d  = res_count_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q & ~m_axis_tready;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = bin_addr;
    ram_wdata    = wr_row;

    case (state_q)
      ibohist_pkg::ST_CLR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + AW'(1);
      end
      ibohist_pkg::ST_IDLE: begin
        if (in_fire) begin
          day_d        = in_day;
          label_d      = in_label;
          start_d      = in_start;
          stop_d       = in_stop;
          bidx_d       = in_bidx;
          dvd_d        = in_start;
          rem_d        = '0;
          bin_d        = '0;
          div_cnt_d    = '0;
          sat_d        = 1'b0;
          clr_cnt_d    = AW'(in_day) * AW'(ibohist_pkg::MAX_BINS);
          res_count_d  = '0;
          res_status_d = ibohist_pkg::STAT_OK;
          if (ibohist_pkg::mode_e'(s_axis_tuser) == ibohist_pkg::MODE_ADD) begin
            if (in_stop < in_start) begin
              res_status_d = ibohist_pkg::STAT_REVERSED;
            end else if (32'(in_day) >= ibohist_pkg::DAYS
                         || 32'(in_label) >= ibohist_pkg::LABELS) begin
              res_status_d = ibohist_pkg::STAT_CLIPPED;
            end
          end
        end
      end
      ibohist_pkg::ST_DIV: begin
        rem_d     = rem_nxt;
        dvd_d     = {dvd_q[SW-2:0], 1'b0};
        bin_d     = {bin_q[SW-2:0], trial_ge};
        div_cnt_d = div_cnt_q + 5'd1;
        if (div_last) lo_d = start_q - rem_nxt;
      end
      ibohist_pkg::ST_CHECK: begin
        ov_d = ov;
        if (go) begin
          ram_en = 1'b1;
        end else if (sat_q) begin
          res_status_d = ibohist_pkg::STAT_SATURATE;
        end else if (clipped) begin
          res_status_d = ibohist_pkg::STAT_CLIPPED;
        end
      end
      ibohist_pkg::ST_MOD: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
        if (sum > (CW + 2)'(ibohist_pkg::COUNT_MAX)) sat_d = 1'b1;
        lo_d  = hi[SW-1:0];
        bin_d = bin_q + SW'(1);
      end
      ibohist_pkg::ST_RDISSUE: begin
        rd_ok_d  = rd_ok;
        ram_en   = rd_ok;
        ram_addr = rd_addr;
      end
      ibohist_pkg::ST_RDWAIT: begin
        res_count_d = rd_ok_q ? lane : '0;
      end
      ibohist_pkg::ST_DAYCLR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + AW'(1);
      end
      ibohist_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_count_d  = res_count_q;
          out_status_d = res_status_q;
        end
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ibohist_pkg::ST_CLR;
      bin_seconds_q <= SW'(ibohist_pkg::BW_RESET);
      clr_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
      div_cnt_q     <= '0;
    end else begin
      state_q       <= state_d;
      bin_seconds_q <= bin_seconds_d;
      clr_cnt_q     <= clr_cnt_d;
      out_valid_q   <= out_valid_d;
      div_cnt_q     <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    day_q        <= day_d;
    label_q      <= label_d;
    start_q      <= start_d;
    stop_q       <= stop_d;
    bidx_q       <= bidx_d;
    dvd_q        <= dvd_d;
    rem_q        <= rem_d;
    bin_q        <= bin_d;
    lo_q         <= lo_d;
    ov_q         <= ov_d;
    sat_q        <= sat_d;
    rd_ok_q      <= rd_ok_d;
    res_count_q  <= res_count_d;
    res_status_q <= res_status_d;
    out_count_q  <= out_count_d;
    out_status_q <= out_status_d;
  end

endmodule

/* hdl/ibohist_ram.sv */
// Generic single-port synchronous RAM with registered read data.
module ibohist_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench of interval_bin_occupancy_histogram_core: stream traffic, APB setup, scoreboard.
module tb;
  import ibohist_pkg::*;

  localparam int STALL_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 600;
  localparam int PHASE_ITEMS  = 155;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    status_e          status;
  } occ_result_t;

  typedef struct {
    mode_e          mode;
    bit [2:0]       day;
    bit [2:0]       label;
    bit [SEC_W-1:0] start_s;
    bit [SEC_W-1:0] stop_s;
    bit [7:0]       bin_idx;
  } occ_item_t;

  class occupancy_scoreboard;
    bit [SEC_W-1:0] bin_width;
    bit [CNT_W-1:0] occ [DAYS][MAX_BINS][LABELS];
    occ_result_t    due_results[$];
    int             errors;
    int             results_seen;
    int             status_tally[4];
    int             mode_tally[4];

    function new();
      bin_width = SEC_W'(BW_RESET);
    endfunction

    function int unsigned usable_bins();
      int unsigned w;
      int unsigned n;
      w = (bin_width == 0) ? 1 : bin_width;
      n = SECONDS_PER_DAY / w;
      return (n > MAX_BINS) ? MAX_BINS : n;
    endfunction

    // Updates the counter store for one accepted beat and queues its result.
    function void account_item(occ_item_t it);
      int unsigned w, nb, first, last, top, lo, hi, a, e, ov, sum, b, l;
      bit          clipped;
      bit          sat;
      occ_result_t r;
      w = (bin_width == 0) ? 1 : bin_width;
      nb = usable_bins();
      r.count = '0;
      r.status = STAT_OK;
      clipped = 1'b0;
      sat = 1'b0;
      case (it.mode)
        MODE_ADD: begin
          if (it.stop_s < it.start_s) begin
            r.status = STAT_REVERSED;
          end else if (it.day >= DAYS || it.label >= LABELS) begin
            r.status = STAT_CLIPPED;
          end else begin
            first = it.start_s / w;
            last = it.stop_s / w;
            top = (last < nb) ? last : nb - 1;
            for (b = first; b <= top && b < nb; b++) begin
              lo = b * w;
              hi = lo + w;
              a = (it.start_s > lo) ? it.start_s : lo;
              e = (it.stop_s < hi) ? it.stop_s : hi;
              ov = (e > a) ? e - a : 0;
              sum = occ[it.day][b][it.label] + ov;
              if (sum > COUNT_MAX) begin
                sum = COUNT_MAX;
                sat = 1'b1;
              end
              occ[it.day][b][it.label] = CNT_W'(sum);
            end
            // anything past the last whole bin is dropped
            a = (it.start_s > nb * w) ? it.start_s : nb * w;
            clipped = (it.stop_s > a);
            r.status = sat ? STAT_SATURATE : (clipped ? STAT_CLIPPED : STAT_OK);
          end
        end
        MODE_CLEAR: begin
          if (it.day < DAYS) begin
            for (b = 0; b < MAX_BINS; b++) begin
              for (l = 0; l < LABELS; l++) begin
                occ[it.day][b][l] = '0;
              end
            end
          end
        end
        MODE_READ: begin
          if (it.day < DAYS && it.label < LABELS && it.bin_idx < nb) begin
            r.count = occ[it.day][it.bin_idx][it.label];
          end
        end
        default: ;
      endcase
      mode_tally[it.mode]++;
      status_tally[r.status]++;
      due_results.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("tb error: %s", msg);
    endtask

    task check_result(logic [CNT_W-1:0] count, logic [1:0] status);
      occ_result_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        report($sformatf("result %0d with none due: count %0d status %0d",
                         results_seen, count, status));
        return;
      end
      want = due_results.pop_front();
      if (count !== want.count) begin
        report($sformatf("result %0d: count %0d, want %0d", results_seen, count, want.count));
      end
      if (status !== want.status) begin
        report($sformatf("result %0d: status %0d, want %0d", results_seen, status,
                         want.status));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;  // day[2:0], label[5:3], start_second[22:6],
                              // stop_second[39:23], bin_index[47:40]
  logic [1:0]  s_axis_tuser;  // mode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;  // count[15:0]
  logic [1:0]  m_axis_tuser;  // status[1:0]

  occupancy_scoreboard sb;
  int                  send_streak;
  int                  recv_streak;
  bit                  hold_req;
  int                  widths_used;

  interval_bin_occupancy_histogram_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // wait before the next beat; occasionally a run of back-to-back beats
  function automatic int draw_gap(ref int streak);
    if (streak > 0) begin
      streak--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      streak = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic occ_item_t occ_item(mode_e m, int d, int l, int s, int t, int b);
    occ_item_t it;
    it.mode = m;
    it.day = 3'(d);
    it.label = 3'(l);
    it.start_s = SEC_W'(s);
    it.stop_s = SEC_W'(t);
    it.bin_idx = 8'(b);
    return it;
  endfunction

  task automatic send_item(occ_item_t it);
    int gap;
    gap = draw_gap(send_streak);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser <= it.mode;
    s_axis_tdata <= {it.bin_idx, it.stop_s, it.start_s, it.label, it.day};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.account_item(it);
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    idle_input();
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write_check(logic [2:0] addr, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value) begin
      sb.report($sformatf("register %0d reads %0d, wrote %0d", addr, prdata, value));
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_bin_width(int unsigned w);
    drain();
    apb_write_check(3'(4 * REG_BIN_SECONDS), w);
    sb.bin_width = SEC_W'(w);
    widths_used++;
  endtask

  task automatic send_random(int n);
    occ_item_t   it;
    int unsigned w, nb, pick, len;
    repeat (n) begin
      w = sb.bin_width;
      nb = sb.usable_bins();
      // favor a few days and labels so counters build up
      it.day = $urandom_range(0, 1) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
      it.label = $urandom_range(0, 1) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
      it.start_s = SEC_W'($urandom_range(0, 86399));
      it.stop_s = it.start_s;
      it.bin_idx = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, nb - 1))
                                               : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        it.mode = MODE_ADD;
        pick = $urandom_range(0, 19);
        if (pick < 11) begin
          len = $urandom_range(0, 3 * w);
          it.stop_s = (it.start_s + len > 131071) ? SEC_W'(131071) : SEC_W'(it.start_s + len);
        end else if (pick < 14) begin
          it.stop_s = SEC_W'($urandom_range(it.start_s, 86399));
        end else if (pick < 16) begin
          it.stop_s = SEC_W'($urandom_range(0, it.start_s));
        end else if (pick < 19) begin
          it.start_s = SEC_W'($urandom_range(0, 131071));
          it.stop_s = SEC_W'($urandom_range(0, 131071));
        end
      end else if (pick < 93) begin
        it.mode = MODE_READ;
      end else if (pick < 97) begin
        it.mode = MODE_CLEAR;
      end else begin
        it.mode = MODE_NOP;
      end
      send_item(it);
    end
  endtask

  initial begin : result_sink
    int gap;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // long back-pressure so the core fills and stalls its input
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        gap = draw_gap(recv_streak);
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb error: no beat for %0d cycles", STALL_LIMIT);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    sb = new();
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = MODE_NOP;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset width, 24 bins
    send_item(occ_item(MODE_ADD, 0, 0, 0, 86399, 0));
    send_item(occ_item(MODE_READ, 0, 0, 0, 0, 0));
    send_item(occ_item(MODE_READ, 0, 0, 0, 0, 23));
    send_item(occ_item(MODE_READ, 0, 0, 0, 0, 24));
    send_item(occ_item(MODE_READ, 6, 7, 0, 0, 255));
    send_item(occ_item(MODE_ADD, 6, 7, 100, 100, 0));
    send_item(occ_item(MODE_ADD, 6, 7, 5000, 4999, 0));
    send_item(occ_item(MODE_ADD, 7, 3, 10, 20, 0));
    send_item(occ_item(MODE_ADD, 7, 3, 20, 10, 0));
    send_item(occ_item(MODE_ADD, 6, 7, 86000, 131071, 0));
    send_item(occ_item(MODE_ADD, 6, 7, 131071, 131071, 0));
    send_item(occ_item(MODE_ADD, 6, 7, 100000, 120000, 0));
    send_item(occ_item(MODE_READ, 6, 7, 0, 0, 23));
    send_item(occ_item(MODE_READ, 7, 0, 0, 0, 0));
    send_item(occ_item(MODE_CLEAR, 7, 0, 0, 0, 0));
    send_item(occ_item(MODE_CLEAR, 0, 0, 0, 0, 0));
    send_item(occ_item(MODE_READ, 0, 0, 0, 0, 0));
    send_item(occ_item(MODE_NOP, 7, 7, 131071, 131071, 255));
    send_item(occ_item(MODE_ADD, 3, 5, 3599, 3600, 0));
    send_item(occ_item(MODE_READ, 3, 5, 0, 0, 0));

    // one bin per day: saturation, and saturation over clipping
    set_bin_width(86400);
    send_item(occ_item(MODE_ADD, 1, 2, 0, 86399, 0));
    send_item(occ_item(MODE_ADD, 1, 2, 0, 10, 0));
    send_item(occ_item(MODE_READ, 1, 2, 0, 0, 0));
    send_item(occ_item(MODE_ADD, 1, 4, 0, 131071, 0));
    send_item(occ_item(MODE_READ, 1, 2, 0, 0, 1));

    set_bin_width(BW_RESET);
    send_random(40);
    hold_req = 1'b1;
    send_random(PHASE_ITEMS - 40);
    set_bin_width(338);
    send_random(PHASE_ITEMS);
    set_bin_width(86400);
    send_random(PHASE_ITEMS);
    set_bin_width($urandom_range(338, 86400));
    send_random(PHASE_ITEMS);
    set_bin_width($urandom_range(338, 2000));
    send_random(PHASE_ITEMS);
    set_bin_width($urandom_range(2001, 86400));
    send_random(PHASE_ITEMS);

    idle_input();
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d adds, %0d clears, %0d reads, %0d no-ops over %0d bin widths",
             sb.mode_tally[MODE_ADD], sb.mode_tally[MODE_CLEAR], sb.mode_tally[MODE_READ],
             sb.mode_tally[MODE_NOP], widths_used + 1);
    $display("tb: %0d results, %0d reversed, %0d clipped, %0d saturated, %0d mismatches",
             sb.results_seen, sb.status_tally[STAT_REVERSED], sb.status_tally[STAT_CLIPPED],
             sb.status_tally[STAT_SATURATE], sb.errors);
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
